>>> hw/rtl/bba_pkg.sv
// Shared types, codes and constants of the bitmap block allocator.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none
package bba_pkg;

   localparam int MAX_BLOCKS_DEF = 1024;

   localparam int SIZE_W   = 23;
   localparam int OFFSET_W = 22;
   localparam int BSIZE_W  = 13;
   localparam int BCOUNT_W = 11;
   localparam int STATUS_W = 2;
   localparam int CMD_W    = 2;
   localparam int MARK_W   = 2;

   localparam logic [BSIZE_W-1:0]  BSIZE_RESET  = 13'd32;
   localparam logic [BSIZE_W-1:0]  BSIZE_MAX    = 13'd4096;
   localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 11'd1024;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 1'b1;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE   = 2'd2;

   localparam logic [MARK_W-1:0] MARK_FREE  = 2'd0;
   localparam logic [MARK_W-1:0] MARK_CONT  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_START = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [SIZE_W-1:0]   size_bytes;
      logic [OFFSET_W-1:0] release_offset;
   } bba_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] grant_offset;
   } bba_rsp_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_DIV_START,
      OP_ALLOC_INIT,
      OP_ALLOC_SCAN,
      OP_ALLOC_MARK,
      OP_FREE_INIT,
      OP_FREE_SCAN,
      OP_SWEEP,
      OP_RESPOND
   } bba_op_type;

   typedef struct packed {
      bba_op_type          op;
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_grant;
   } bba_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             div_done;
      logic             need_ok;
      logic             free_ok;
      logic             scan_hit;
      logic             scan_miss;
      logic             mark_last;
      logic             free_bad;
      logic             free_end;
      logic             sweep_last;
      logic             rsp_free;
   } bba_sts_type;

endpackage
`default_nettype wire

>>> hw/rtl/bitmap_block_allocator_core.sv
// Top level of the first-fit bitmap block allocator: controller plus datapath.
// Depends on bba_pkg, bba_controller, bba_datapath (and bba_divider below it).
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data  (bba_req_type)
//   rsp      out        rsp_valid/rsp_ready    rsp_data  (bba_rsp_type)
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// Allocate: divide the size (divider, one bit a cycle), scan the marks from block 0 up to
//   block_count for a free run, then write one mark per block of that run.
// Free: divide the offset, then clear each block of the run from its start mark on.
// Clear all: all MAX_BLOCKS marks are freed, one mark written a cycle.
// After reset a clearing pass over all MAX_BLOCKS marks runs before the first item is taken.
// A waiting result is held in its register; the next item is taken meanwhile.
`default_nettype none
module bitmap_block_allocator_core #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire bba_pkg::bba_req_type            req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output bba_pkg::bba_rsp_type                 rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bba_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   bba_pkg::bba_cmd_type cmd;
   bba_pkg::bba_sts_type sts;

   assign csr_ready = 1'b1;

   bba_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bba_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

>>> hw/rtl/bba_divider.sv
// Restoring divider: byte count or offset over the block size, one bit a cycle.
// Depends on bba_pkg for widths.
`default_nettype none
module bba_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [bba_pkg::SIZE_W-1:0]  dividend,
   input  wire logic [bba_pkg::BSIZE_W-1:0] divisor,
   output logic                             busy,
   output logic                             done,
   output logic [bba_pkg::SIZE_W-1:0]       quotient,
   output logic [bba_pkg::BSIZE_W-1:0]      remainder
);
   localparam int QW = bba_pkg::SIZE_W;
   localparam int RW = bba_pkg::BSIZE_W;
   localparam int NW = $clog2(QW + 1);

   logic          busy_ff, done_ff;
   logic [NW-1:0] count_ff;
   logic [QW-1:0] quot_ff, quot_in;
   logic [RW-1:0] rem_ff, rem_in, div_ff;
   logic [RW:0]   shifted, diff;

   always_comb begin
      shifted = {rem_ff, quot_ff[QW-1]};
      diff    = shifted - {1'b0, div_ff};
      if (shifted >= {1'b0, div_ff}) begin
         rem_in  = diff[RW-1:0];
         quot_in = {quot_ff[QW-2:0], 1'b1};
      end else begin
         rem_in  = shifted[RW-1:0];
         quot_in = {quot_ff[QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= NW'(QW);
      end else if (busy_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == NW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

>>> hw/rtl/bba_datapath.sv
// Datapath: configuration registers, mark memory, scan counters, divider and result register.
// Depends on bba_pkg and bba_divider; driven by bba_controller through bba_cmd_type.
`default_nettype none
module bba_datapath #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bba_pkg::bba_req_type            req_data,
   input  wire logic                            csr_valid,
   input  wire logic [bba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bba_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire bba_pkg::bba_cmd_type            cmd,
   output bba_pkg::bba_sts_type                 sts,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output bba_pkg::bba_rsp_type                 rsp_data
);
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int XW = (CW > bba_pkg::BCOUNT_W) ? CW : bba_pkg::BCOUNT_W;
   localparam int NW = bba_pkg::SIZE_W + 1;
   localparam int PW = (bba_pkg::BSIZE_W + IW > bba_pkg::OFFSET_W) ?
                       bba_pkg::BSIZE_W + IW : bba_pkg::OFFSET_W;

   logic [bba_pkg::BSIZE_W-1:0]  bsize_ff, bs_eff;
   logic [bba_pkg::BCOUNT_W-1:0] bcount_ff;
   logic [XW-1:0]                cnt_x;
   logic [CW-1:0]                cnt_eff;

   bba_pkg::bba_req_type         req_ff;
   logic [bba_pkg::MARK_W-1:0]   marks_mem [MAX_BLOCKS];
   logic [bba_pkg::MARK_W-1:0]   rd_data_ff, wr_data;
   logic [IW-1:0]                rd_idx_ff, wr_addr, wr_addr_ff, start_ff, start_calc;
   logic                         rd_vld_ff, rd_issue, wr_en;
   logic [CW-1:0]                addr_ff, run_ff, need_ff, wr_left_ff;
   logic                         mark_first_ff, first_ff;
   logic                         free_now, hit;
   logic [PW-1:0]                prod;

   logic                         div_start, div_busy, div_done;
   logic [bba_pkg::SIZE_W-1:0]   dividend, quot;
   logic [bba_pkg::BSIZE_W-1:0]  rem;
   logic [NW-1:0]                need;

   logic                         rsp_valid_ff;
   bba_pkg::bba_rsp_type         rsp_ff;

   // effective register values: clamp into their meaningful ranges
   always_comb begin
      if (bsize_ff == '0) bs_eff = bba_pkg::BSIZE_W'(1);
      else if (bsize_ff > bba_pkg::BSIZE_MAX) bs_eff = bba_pkg::BSIZE_MAX;
      else bs_eff = bsize_ff;
      cnt_x = XW'(bcount_ff);
      if (cnt_x == '0) cnt_eff = CW'(1);
      else if (cnt_x > XW'(MAX_BLOCKS)) cnt_eff = CW'(MAX_BLOCKS);
      else cnt_eff = CW'(cnt_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff  <= bba_pkg::BSIZE_RESET;
         bcount_ff <= bba_pkg::BCOUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            bba_pkg::CSR_BLOCK_SIZE:  bsize_ff  <= csr_wdata;
            bba_pkg::CSR_BLOCK_COUNT: bcount_ff <= csr_wdata[bba_pkg::BCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // divider shared by allocate (size) and free (offset)
   assign div_start = (cmd.op == bba_pkg::OP_DIV_START);
   assign dividend  = (req_ff.command == bba_pkg::CMD_FREE) ?
                      {1'b0, req_ff.release_offset} : req_ff.size_bytes;

   bba_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .divisor   (bs_eff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (quot),
      .remainder (rem)
   );

   assign need = NW'(quot) + NW'(rem != '0);

   // scan evaluation on the registered read data
   assign rd_issue   = ((cmd.op == bba_pkg::OP_ALLOC_SCAN) || (cmd.op == bba_pkg::OP_FREE_SCAN))
                       && (addr_ff < cnt_eff);
   assign free_now   = rd_vld_ff && (rd_data_ff == bba_pkg::MARK_FREE);
   assign hit        = (cmd.op == bba_pkg::OP_ALLOC_SCAN) && free_now
                       && (CW'(run_ff + 1'b1) == need_ff);
   assign start_calc = IW'(CW'(rd_idx_ff) - need_ff + CW'(1));
   assign prod       = PW'(bs_eff) * PW'(start_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_addr_ff;
      wr_data = bba_pkg::MARK_FREE;
      unique case (cmd.op)
         bba_pkg::OP_ALLOC_MARK: begin
            wr_en   = 1'b1;
            wr_data = mark_first_ff ? bba_pkg::MARK_START : bba_pkg::MARK_CONT;
         end
         bba_pkg::OP_FREE_SCAN: begin
            wr_en   = rd_vld_ff && (first_ff ? (rd_data_ff == bba_pkg::MARK_START)
                                             : (rd_data_ff == bba_pkg::MARK_CONT));
            wr_addr = rd_idx_ff;
         end
         bba_pkg::OP_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff[IW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) marks_mem[wr_addr] <= wr_data;
      if (rd_issue) rd_data_ff <= marks_mem[addr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_issue;
         unique case (cmd.op)
            bba_pkg::OP_LOAD, bba_pkg::OP_ALLOC_INIT: addr_ff <= '0;
            bba_pkg::OP_FREE_INIT: addr_ff <= CW'(quot);
            bba_pkg::OP_ALLOC_SCAN, bba_pkg::OP_FREE_SCAN: begin
               if (rd_issue) addr_ff <= addr_ff + 1'b1;
            end
            bba_pkg::OP_SWEEP: addr_ff <= addr_ff + 1'b1;
            default: ;
         endcase
         if (cmd.op == bba_pkg::OP_RESPOND) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff[IW-1:0];
      unique case (cmd.op)
         bba_pkg::OP_LOAD: req_ff <= req_data;
         bba_pkg::OP_ALLOC_INIT: begin
            need_ff <= CW'(need);
            run_ff  <= '0;
         end
         bba_pkg::OP_ALLOC_SCAN: begin
            if (rd_vld_ff) run_ff <= free_now ? CW'(run_ff + 1'b1) : '0;
            if (hit) begin
               start_ff      <= start_calc;
               wr_addr_ff    <= start_calc;
               wr_left_ff    <= need_ff;
               mark_first_ff <= 1'b1;
            end
         end
         bba_pkg::OP_ALLOC_MARK: begin
            wr_addr_ff    <= wr_addr_ff + 1'b1;
            wr_left_ff    <= wr_left_ff - 1'b1;
            mark_first_ff <= 1'b0;
         end
         bba_pkg::OP_FREE_INIT: first_ff <= 1'b1;
         bba_pkg::OP_FREE_SCAN: begin
            if (rd_vld_ff) first_ff <= 1'b0;
         end
         bba_pkg::OP_RESPOND: begin
            rsp_ff.status       <= cmd.rsp_status;
            rsp_ff.grant_offset <= cmd.rsp_grant ? prod[bba_pkg::OFFSET_W-1:0] : '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      sts.command    = req_ff.command;
      sts.div_done   = div_done;
      sts.need_ok    = (req_ff.size_bytes != '0) && (need <= NW'(cnt_eff));
      sts.free_ok    = (rem == '0) && (NW'(quot) < NW'(cnt_eff));
      sts.scan_hit   = hit;
      sts.scan_miss  = !rd_vld_ff && (addr_ff >= cnt_eff);
      sts.mark_last  = (wr_left_ff == CW'(1));
      sts.free_bad   = rd_vld_ff && first_ff && (rd_data_ff != bba_pkg::MARK_START);
      sts.free_end   = (rd_vld_ff && !first_ff && (rd_data_ff != bba_pkg::MARK_CONT))
                       || (!rd_vld_ff && (addr_ff >= cnt_eff));
      sts.sweep_last = (addr_ff == CW'(MAX_BLOCKS - 1));
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_write_ops: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cmd.op == bba_pkg::OP_ALLOC_MARK || cmd.op == bba_pkg::OP_FREE_SCAN
                 || cmd.op == bba_pkg::OP_SWEEP))
      else $error("mark write outside a writing phase");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bba_pkg::OP_DIV_START) |-> !div_busy)
      else $error("divider restarted while busy");
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bba_pkg::OP_RESPOND) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");
endmodule
`default_nettype wire

>>> hw/rtl/bba_controller.sv
// Sequencer of the allocator: decodes each item and steps the datapath through its phases.
// Depends on bba_pkg for the command and status structs.
`default_nettype none
module bba_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire bba_pkg::bba_sts_type sts,
   output bba_pkg::bba_cmd_type      cmd
);
   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DISPATCH, S_DIV, S_ASCAN, S_AMARK, S_FSCAN, S_CLEAR, S_DONE
   } ctl_state_type;

   ctl_state_type                state_ff;
   logic [bba_pkg::STATUS_W-1:0] res_status_ff;
   logic                         res_grant_ff;
   logic                         is_alloc, is_work;

   assign is_alloc  = (sts.command == bba_pkg::CMD_ALLOC);
   assign is_work   = is_alloc || (sts.command == bba_pkg::CMD_FREE);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd.op         = bba_pkg::OP_IDLE;
      cmd.rsp_status = res_status_ff;
      cmd.rsp_grant  = res_grant_ff;
      unique case (state_ff)
         S_INIT, S_CLEAR: cmd.op = bba_pkg::OP_SWEEP;
         S_IDLE: if (req_valid) cmd.op = bba_pkg::OP_LOAD;
         S_DISPATCH: if (is_work) cmd.op = bba_pkg::OP_DIV_START;
         S_DIV: begin
            if (sts.div_done) begin
               if (is_alloc && sts.need_ok) cmd.op = bba_pkg::OP_ALLOC_INIT;
               else if (!is_alloc && sts.free_ok) cmd.op = bba_pkg::OP_FREE_INIT;
            end
         end
         S_ASCAN: cmd.op = bba_pkg::OP_ALLOC_SCAN;
         S_AMARK: cmd.op = bba_pkg::OP_ALLOC_MARK;
         S_FSCAN: cmd.op = bba_pkg::OP_FREE_SCAN;
         S_DONE:  if (sts.rsp_free) cmd.op = bba_pkg::OP_RESPOND;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         res_status_ff <= bba_pkg::ST_OK;
         res_grant_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_INIT: if (sts.sweep_last) state_ff <= S_IDLE;
            S_IDLE: if (req_valid) state_ff <= S_DISPATCH;
            S_DISPATCH: begin
               res_status_ff <= bba_pkg::ST_OK;
               res_grant_ff  <= 1'b0;
               if (is_work) state_ff <= S_DIV;
               else if (sts.command == bba_pkg::CMD_CLEAR) state_ff <= S_CLEAR;
               else state_ff <= S_DONE;
            end
            S_DIV: begin
               if (sts.div_done) begin
                  priority if (is_alloc && sts.need_ok) state_ff <= S_ASCAN;
                  else if (is_alloc) begin
                     res_status_ff <= bba_pkg::ST_ALLOC_FAIL;
                     state_ff      <= S_DONE;
                  end else if (sts.free_ok) state_ff <= S_FSCAN;
                  else begin
                     res_status_ff <= bba_pkg::ST_BAD_FREE;
                     state_ff      <= S_DONE;
                  end
               end
            end
            S_ASCAN: begin
               priority if (sts.scan_hit) state_ff <= S_AMARK;
               else if (sts.scan_miss) begin
                  res_status_ff <= bba_pkg::ST_ALLOC_FAIL;
                  state_ff      <= S_DONE;
               end else state_ff <= S_ASCAN;
            end
            S_AMARK: begin
               if (sts.mark_last) begin
                  res_grant_ff <= 1'b1;
                  state_ff     <= S_DONE;
               end
            end
            S_FSCAN: begin
               priority if (sts.free_bad) begin
                  res_status_ff <= bba_pkg::ST_BAD_FREE;
                  state_ff      <= S_DONE;
               end else if (sts.free_end) state_ff <= S_DONE;
               else state_ff <= S_FSCAN;
            end
            S_CLEAR: if (sts.sweep_last) state_ff <= S_DONE;
            S_DONE:  if (sts.rsp_free) state_ff <= S_IDLE;
            default: state_ff <= S_INIT;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking bench for bitmap_block_allocator_core: directed and random allocate, free,
// clear and register traffic, checked against an in-bench first-fit mark table.
// Depends on bba_pkg and the allocator RTL only.
module testbench;
   import bba_pkg::*;

   localparam int POOL         = MAX_BLOCKS_DEF;
   localparam int IDLE_LIMIT   = 30000;
   localparam int HOLD_CYCLES  = 1500;
   localparam logic [OFFSET_W-1:0] OFFSET_ALL = '1;
   localparam logic [CMD_W-1:0]    CMD_SPARE  = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bba_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bba_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bitmap_block_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror of the allocator state
   logic [MARK_W-1:0]   mark_table [POOL];
   logic [BSIZE_W-1:0]  cur_bsize  = BSIZE_RESET;
   logic [BCOUNT_W-1:0] cur_bcount = BCOUNT_RESET;
   bba_rsp_type         pending_rsp [$];
   logic [OFFSET_W-1:0] live_runs [$];

   int  error_count = 0;
   int  items_sent = 0;
   int  rsp_seen = 0;
   int  grants_seen = 0;
   int  frees_ok = 0;
   bit  no_idle = 0;
   bit  hold_req = 0;

   function automatic int eff_bsize();
      if (cur_bsize == 0) return 1;
      if (cur_bsize > BSIZE_MAX) return int'(BSIZE_MAX);
      return int'(cur_bsize);
   endfunction

   function automatic int eff_bcount();
      if (cur_bcount == 0) return 1;
      if (cur_bcount > POOL) return POOL;
      return int'(cur_bcount);
   endfunction

   // first-fit bookkeeping for one item; updates the mark table and live run list
   function automatic bba_rsp_type allocator_outcome(bba_req_type r);
      bba_rsp_type res;
      longint bs, bc, need, loc, run, blk, sz, off;
      bs = eff_bsize();
      bc = eff_bcount();
      res = '0;
      res.status = ST_OK;
      if (r.command == CMD_ALLOC) begin
         res.status = ST_ALLOC_FAIL;
         sz = r.size_bytes;
         if (sz != 0) begin
            need = (sz + bs - 1) / bs;
            loc = 0;
            if (need <= bc) begin
               while (loc + need <= bc) begin
                  run = 0;
                  while (run < need && mark_table[loc + run] == MARK_FREE) run++;
                  if (run == need) begin
                     mark_table[loc] = MARK_START;
                     for (longint i = 1; i < need; i++) mark_table[loc + i] = MARK_CONT;
                     res.status = ST_OK;
                     res.grant_offset = OFFSET_W'(bs * loc);
                     live_runs.push_back(res.grant_offset);
                     break;
                  end
                  loc += run + 1;
               end
            end
         end
      end else if (r.command == CMD_FREE) begin
         off = r.release_offset;
         blk = off / bs;
         if (off % bs != 0 || blk >= bc || mark_table[blk] != MARK_START) begin
            res.status = ST_BAD_FREE;
         end else begin
            mark_table[blk] = MARK_FREE;
            blk++;
            while (blk < bc && mark_table[blk] == MARK_CONT) begin
               mark_table[blk] = MARK_FREE;
               blk++;
            end
            for (int i = 0; i < live_runs.size(); i++)
               if (live_runs[i] == r.release_offset) begin
                  live_runs.delete(i);
                  break;
               end
         end
      end else if (r.command == CMD_CLEAR) begin
         foreach (mark_table[i]) mark_table[i] = MARK_FREE;
         live_runs.delete();
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int p;
      if (no_idle) return 0;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(bba_req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      pending_rsp.push_back(allocator_outcome(r));
      items_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_cmd(logic [CMD_W-1:0] c, int unsigned sz, int unsigned off);
      bba_req_type r;
      r.command = c;
      r.size_bytes = SIZE_W'(sz);
      r.release_offset = OFFSET_W'(off);
      send_item(r);
   endtask

   // hold the sender until every expected item has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, int unsigned val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_BLOCK_SIZE) cur_bsize = BSIZE_W'(val);
      else cur_bcount = BCOUNT_W'(val);
   endtask

   task automatic configure(int unsigned bs, int unsigned bc);
      drain();
      write_reg(CSR_BLOCK_SIZE, bs);
      write_reg(CSR_BLOCK_COUNT, bc);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin : rsp_side
      static int stall = 0;
      if (hold_req) begin
         stall = HOLD_CYCLES;
         hold_req = 0;
      end
      if (stall > 0) begin
         rsp_ready <= 1'b0;
         stall--;
      end else if (no_idle || $urandom_range(99) < 65) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         stall = ($urandom_range(99) < 90) ? $urandom_range(0, 3) : $urandom_range(10, 50);
      end
   end

   always @(posedge clock) begin : rsp_check
      bba_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("result with no item outstanding: %p", rsp_data);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (want.status == ST_OK && rsp_data.grant_offset != 0) grants_seen++;
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.grant_offset !== want.grant_offset) begin
               $error("grant_offset: expected %0d, got %0d",
                      want.grant_offset, rsp_data.grant_offset);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      static int quiet = 0;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         quiet = 0;
      else
         quiet++;
      if (quiet >= IDLE_LIMIT) begin
         $display("stalled for %0d cycles with %0d items outstanding",
                  quiet, pending_rsp.size());
         $display("testbench failed");
         $finish;
      end
   end

   task automatic test_defaults();
      // reset settings: 32-byte blocks, 1024 blocks
      send_cmd(CMD_ALLOC, 1, 0);
      send_cmd(CMD_ALLOC, 33, 0);
      send_cmd(CMD_ALLOC, 0, 0);
      send_cmd(CMD_ALLOC, 32 * 1024 + 1, 0);
      send_cmd(CMD_ALLOC, 4194304, 0);
      send_cmd(CMD_ALLOC, 23'h7FFFFF, OFFSET_ALL);
      send_cmd(CMD_FREE, 0, 5);
      send_cmd(CMD_FREE, 0, 64);
      send_cmd(CMD_FREE, 0, 32 * 1024);
      send_cmd(CMD_FREE, 0, OFFSET_ALL);
      send_cmd(CMD_FREE, 0, 32);
      send_cmd(CMD_FREE, 0, 32);
      send_cmd(CMD_SPARE, 23'h7FFFFF, OFFSET_ALL);
      send_cmd(CMD_ALLOC, 32 * 1024, 0);
      send_cmd(CMD_ALLOC, 1, 0);
      send_cmd(CMD_CLEAR, 0, 0);
      send_cmd(CMD_ALLOC, 32 * 1024, 0);
      send_cmd(CMD_FREE, 0, 0);
   endtask

   task automatic test_register_extremes();
      configure(0, 0);   // both act as one
      send_cmd(CMD_ALLOC, 1, 0);
      send_cmd(CMD_ALLOC, 1, 0);
      send_cmd(CMD_ALLOC, 2, 0);
      send_cmd(CMD_FREE, 0, 0);
      configure(8191, 2047);   // clamp to 4096 and the pool size
      send_cmd(CMD_ALLOC, 4194304, 0);
      send_cmd(CMD_ALLOC, 4097, 0);
      send_cmd(CMD_FREE, 0, 4096);
      send_cmd(CMD_FREE, 0, 0);
      configure(4096, 2);
      send_cmd(CMD_ALLOC, 4096, 0);
      send_cmd(CMD_ALLOC, 4096, 0);
      // a shrunk count hides the second run until it grows again
      configure(4096, 1);
      send_cmd(CMD_FREE, 0, 4096);
      configure(4096, 2);
      send_cmd(CMD_FREE, 0, 4096);
      send_cmd(CMD_CLEAR, 0, 0);
   endtask

   task automatic test_backpressure();
      configure(3, 16);
      hold_req = 1;
      no_idle = 1;
      for (int i = 0; i < 20; i++) send_cmd(CMD_ALLOC, $urandom_range(1, 9), 0);
      no_idle = 0;
      drain();
      for (int i = 0; i < 8; i++) send_cmd(CMD_FREE, 0, 3 * $urandom_range(0, 15));
   endtask

   task automatic random_phase(int unsigned bs, int unsigned bc, int count);
      int p, ebs, ebc, pick;
      configure(bs, bc);
      ebs = eff_bsize();
      ebc = eff_bcount();
      no_idle = ($urandom_range(3) == 0);
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(99);
         if (p < 42) begin
            if ($urandom_range(9) == 0)
               send_cmd(CMD_ALLOC, $urandom_range(1, ebs * ebc), 0);
            else
               send_cmd(CMD_ALLOC, $urandom_range(1, ebs * 4), 0);
         end else if (p < 78 && live_runs.size() != 0) begin
            pick = $urandom_range(live_runs.size() - 1);
            send_cmd(CMD_FREE, 0, live_runs[pick]);
         end else if (p < 86) begin
            send_cmd(CMD_FREE, 0, ($urandom_range(3) == 0) ? $urandom() :
                     $urandom_range(0, ebs * (ebc + 1)));
         end else if (p < 89) begin
            send_cmd(CMD_CLEAR, 0, 0);
         end else if (p < 94) begin
            send_cmd(CMD_ALLOC, ($urandom_range(1) == 0) ? 0 : ebs * ebc + 1, 0);
         end else begin
            send_cmd($urandom_range(3), $urandom(), $urandom());
         end
      end
      no_idle = 0;
   endtask

   initial begin
      foreach (mark_table[i]) mark_table[i] = MARK_FREE;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_register_extremes();
      test_backpressure();
      random_phase(1, 8, 70);
      random_phase($urandom_range(1, 4096), $urandom_range(4, 64), 70);
      random_phase(4096, 1024, 60);
      random_phase(0, 1, 40);
      random_phase($urandom_range(5, 200), $urandom_range(16, 128), 80);
      random_phase(8191, 2047, 40);
      random_phase($urandom_range(1, 64), 2, 50);
      random_phase($urandom_range(1, 4096), $urandom_range(3, 40), 70);
      drain();
      repeat (50) @(posedge clock);
      $display("%0d items sent, %0d results checked, %0d non-zero grants, errors %0d",
               items_sent, rsp_seen, grants_seen, error_count);
      $display("covered clamped registers, bad frees, clears, unused command, long stall");
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
